// ----- rtl/radio_link_connection_manager_assert.svh -----
`ifndef RADIO_LINK_CONNECTION_MANAGER_ASSERT_SVH
`define RADIO_LINK_CONNECTION_MANAGER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RLCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlcm assertion failed");

// next-cycle implication, checked outside reset
`define RLCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlcm assertion failed");

`endif

// ----- rtl/rlcm_pkg.sv -----
package rlcm_pkg;

    localparam logic [9:0]  MAX_PAYLOAD = 10'd248;
    localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

    // opcodes
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_TIME  = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;
    localparam logic [1:0] OP_SEND  = 2'd3;

    // link modes
    localparam logic [1:0] MODE_UNINIT     = 2'd0;
    localparam logic [1:0] MODE_SCAN       = 2'd1;
    localparam logic [1:0] MODE_CONNECTING = 2'd2;
    localparam logic [1:0] MODE_CONNECTED  = 2'd3;

    // received frame kinds
    localparam logic [1:0] RX_OFFER  = 2'd0;
    localparam logic [1:0] RX_ACCEPT = 2'd1;
    localparam logic [1:0] RX_PONG   = 2'd2;

    // sent frame kinds
    localparam logic [1:0] TX_DISCOVER = 2'd0;
    localparam logic [1:0] TX_CONNREQ  = 2'd1;
    localparam logic [1:0] TX_PING     = 2'd2;
    localparam logic [1:0] TX_DATA     = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_INIT    = 3'd1;
    localparam logic [2:0] ST_BAD_CONFIG  = 3'd2;
    localparam logic [2:0] ST_BAD_ARG     = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd4;
    localparam logic [2:0] ST_WOULD_BLOCK = 3'd5;
    localparam logic [2:0] ST_INTERNAL    = 3'd6;

    // register indexes
    localparam logic [2:0] REG_FIRST_CHANNEL = 3'd0;
    localparam logic [2:0] REG_MAX_CHANNEL   = 3'd1;
    localparam logic [2:0] REG_DWELL         = 3'd2;
    localparam logic [2:0] REG_CONN_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_PING_INTERVAL = 3'd4;
    localparam logic [2:0] REG_MAX_MISSED    = 3'd5;

    localparam int LIVE_W = 25;

    typedef struct packed {
        logic [3:0]        first_channel;
        logic [3:0]        max_channel;
        logic [15:0]       dwell_ms;
        logic [15:0]       connect_timeout_ms;
        logic [15:0]       ping_interval_ms;
        logic [7:0]        max_missed_pongs;
        logic [LIVE_W-1:0] live_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic        header_valid;
        logic [1:0]  frame_kind;
        logic [47:0] source_mac;
        logic [9:0]  payload_len;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  link_state;
        logic        tune_channel;
        logic [3:0]  channel;
        logic        send_frame;
        logic [1:0]  sent_kind;
        logic [47:0] destination_mac;
        logic [31:0] reconnect_total;
        logic [31:0] bad_header_total;
        logic [31:0] data_sent_total;
    } t_result;

    // elapsed time modulo 2^32 against an interval
    function automatic logic f_passed(logic [31:0] now, logic [31:0] start,
                                      logic [31:0] interval);
        logic [31:0] elapsed;
        elapsed = now - start;
        return elapsed >= interval;
    endfunction

endpackage

// ----- rtl/rlcm_core.sv -----
module rlcm_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  rlcm_pkg::t_item  i_item,
    input  rlcm_pkg::t_cfg   i_cfg,
    output rlcm_pkg::t_result o_res
);

    logic        r_ready, n_ready;
    logic [1:0]  r_mode, n_mode;
    logic [3:0]  r_scan_pos, n_scan_pos;
    logic        r_retune, n_retune;
    logic [31:0] r_dwell_start, n_dwell_start;
    logic [31:0] r_conn_start, n_conn_start;
    logic [31:0] r_pong_time, n_pong_time;
    logic [31:0] r_ping_time, n_ping_time;
    logic [47:0] r_server_mac, n_server_mac;
    logic [31:0] r_reconnect, n_reconnect;
    logic [31:0] r_bad_header, n_bad_header;
    logic [31:0] r_data_sent, n_data_sent;

    logic w_cfg_bad;
    logic w_dwell_done, w_conn_done, w_live_done, w_ping_done;
    logic w_mac_match;

    assign w_cfg_bad = (i_cfg.dwell_ms == 16'd0) || (i_cfg.connect_timeout_ms == 16'd0)
                    || (i_cfg.ping_interval_ms == 16'd0) || (i_cfg.max_missed_pongs == 8'd0)
                    || (i_cfg.first_channel == 4'd0)
                    || (i_cfg.first_channel > i_cfg.max_channel);

    assign w_dwell_done = rlcm_pkg::f_passed(i_item.now_ms, r_dwell_start,
                                             {16'd0, i_cfg.dwell_ms});
    assign w_conn_done  = rlcm_pkg::f_passed(i_item.now_ms, r_conn_start,
                                             {16'd0, i_cfg.connect_timeout_ms});
    assign w_live_done  = rlcm_pkg::f_passed(i_item.now_ms, r_pong_time,
                                             {{(32-rlcm_pkg::LIVE_W){1'b0}}, i_cfg.live_ms});
    assign w_ping_done  = rlcm_pkg::f_passed(i_item.now_ms, r_ping_time,
                                             {16'd0, i_cfg.ping_interval_ms});
    assign w_mac_match  = (i_item.source_mac == r_server_mac);

    always_comb begin
        n_ready       = r_ready;
        n_mode        = r_mode;
        n_scan_pos    = r_scan_pos;
        n_retune      = r_retune;
        n_dwell_start = r_dwell_start;
        n_conn_start  = r_conn_start;
        n_pong_time   = r_pong_time;
        n_ping_time   = r_ping_time;
        n_server_mac  = r_server_mac;
        n_reconnect   = r_reconnect;
        n_bad_header  = r_bad_header;
        n_data_sent   = r_data_sent;

        o_res = '0;

        if (i_item.opcode == rlcm_pkg::OP_BEGIN) begin
            n_ready = 1'b0;
            n_mode  = rlcm_pkg::MODE_UNINIT;
            if (w_cfg_bad) begin
                o_res.status = rlcm_pkg::ST_BAD_CONFIG;
            end else begin
                n_scan_pos = i_cfg.first_channel;
                n_mode     = rlcm_pkg::MODE_SCAN;
                n_retune   = 1'b1;
                n_ready    = 1'b1;
            end
        end else if (!r_ready) begin
            o_res.status = rlcm_pkg::ST_NOT_INIT;
        end else begin
            unique case (i_item.opcode)
                rlcm_pkg::OP_TIME: begin
                    unique case (r_mode)
                        rlcm_pkg::MODE_SCAN: begin
                            if (r_retune || w_dwell_done) begin
                                if (!r_retune) begin
                                    n_scan_pos = (r_scan_pos >= i_cfg.max_channel) ? 4'd1
                                               : 4'(r_scan_pos + 4'd1);
                                end
                                n_retune              = 1'b0;
                                n_dwell_start         = i_item.now_ms;
                                o_res.tune_channel    = 1'b1;
                                o_res.channel         = n_scan_pos;
                                o_res.send_frame      = 1'b1;
                                o_res.sent_kind       = rlcm_pkg::TX_DISCOVER;
                                o_res.destination_mac = rlcm_pkg::MAC_BCAST;
                            end
                        end
                        rlcm_pkg::MODE_CONNECTING: begin
                            if (w_conn_done) begin
                                n_mode   = rlcm_pkg::MODE_SCAN;
                                n_retune = 1'b1;
                            end
                        end
                        rlcm_pkg::MODE_CONNECTED: begin
                            if (w_live_done) begin
                                n_reconnect = r_reconnect + 32'd1;
                                n_mode      = rlcm_pkg::MODE_SCAN;
                                n_retune    = 1'b1;
                            end else if (w_ping_done) begin
                                n_ping_time           = i_item.now_ms;
                                o_res.send_frame      = 1'b1;
                                o_res.sent_kind       = rlcm_pkg::TX_PING;
                                o_res.destination_mac = r_server_mac;
                            end
                        end
                        default: begin
                            o_res.status = rlcm_pkg::ST_INTERNAL;
                        end
                    endcase
                end
                rlcm_pkg::OP_FRAME: begin
                    if (!i_item.header_valid) begin
                        n_bad_header = r_bad_header + 32'd1;
                    end else if (r_mode == rlcm_pkg::MODE_SCAN) begin
                        if (i_item.frame_kind == rlcm_pkg::RX_OFFER) begin
                            n_server_mac          = i_item.source_mac;
                            n_conn_start          = i_item.now_ms;
                            n_mode                = rlcm_pkg::MODE_CONNECTING;
                            o_res.send_frame      = 1'b1;
                            o_res.sent_kind       = rlcm_pkg::TX_CONNREQ;
                            o_res.destination_mac = i_item.source_mac;
                        end
                    end else if (r_mode == rlcm_pkg::MODE_CONNECTING) begin
                        if (i_item.frame_kind == rlcm_pkg::RX_ACCEPT && w_mac_match) begin
                            n_mode      = rlcm_pkg::MODE_CONNECTED;
                            n_pong_time = i_item.now_ms;
                            n_ping_time = i_item.now_ms;
                        end
                    end else if (r_mode == rlcm_pkg::MODE_CONNECTED) begin
                        if (i_item.frame_kind == rlcm_pkg::RX_PONG && w_mac_match) begin
                            n_pong_time = i_item.now_ms;
                        end
                    end
                end
                default: begin
                    if (i_item.payload_len == 10'd0) begin
                        o_res.status = rlcm_pkg::ST_BAD_ARG;
                    end else if (i_item.payload_len > rlcm_pkg::MAX_PAYLOAD) begin
                        o_res.status = rlcm_pkg::ST_TOO_LARGE;
                    end else if (r_mode != rlcm_pkg::MODE_CONNECTED) begin
                        o_res.status = rlcm_pkg::ST_WOULD_BLOCK;
                    end else begin
                        o_res.send_frame      = 1'b1;
                        o_res.sent_kind       = rlcm_pkg::TX_DATA;
                        o_res.destination_mac = r_server_mac;
                        n_data_sent           = r_data_sent + 32'd1;
                    end
                end
            endcase
        end

        o_res.link_state       = n_mode;
        o_res.reconnect_total  = n_reconnect;
        o_res.bad_header_total = n_bad_header;
        o_res.data_sent_total  = n_data_sent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready       <= 1'b0;
            r_mode        <= rlcm_pkg::MODE_UNINIT;
            r_scan_pos    <= 4'd0;
            r_retune      <= 1'b0;
            r_dwell_start <= 32'd0;
            r_conn_start  <= 32'd0;
            r_pong_time   <= 32'd0;
            r_ping_time   <= 32'd0;
            r_server_mac  <= 48'd0;
            r_reconnect   <= 32'd0;
            r_bad_header  <= 32'd0;
            r_data_sent   <= 32'd0;
        end else if (i_fire) begin
            r_ready       <= n_ready;
            r_mode        <= n_mode;
            r_scan_pos    <= n_scan_pos;
            r_retune      <= n_retune;
            r_dwell_start <= n_dwell_start;
            r_conn_start  <= n_conn_start;
            r_pong_time   <= n_pong_time;
            r_ping_time   <= n_ping_time;
            r_server_mac  <= n_server_mac;
            r_reconnect   <= n_reconnect;
            r_bad_header  <= n_bad_header;
            r_data_sent   <= n_data_sent;
        end
    end

`include "radio_link_connection_manager_assert.svh"

    // a ready link is never in the uninitialized mode
    `RLCM_ASSERT_NOW(a_ready_mode, r_ready, r_mode != rlcm_pkg::MODE_UNINIT)

    // a retune always names a real channel
    `RLCM_ASSERT_NOW(a_tune_chan, i_fire && o_res.tune_channel, o_res.channel != 4'd0)

    // a data frame bumps the sent counter by exactly one
    `RLCM_ASSERT_NEXT(a_data_count,
        i_fire && o_res.send_frame && o_res.sent_kind == rlcm_pkg::TX_DATA,
        r_data_sent == $past(r_data_sent) + 32'd1)

    // items before a good begin leave the mode alone
    `RLCM_ASSERT_NEXT(a_uninit_hold,
        i_fire && !r_ready && i_item.opcode != rlcm_pkg::OP_BEGIN,
        $stable(r_mode) && $stable(r_ready))

endmodule

// ----- rtl/radio_link_connection_manager.sv -----
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: opcode; tdata: event fields
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: result fields
// cfg       in   i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the m_axis side does not stall; each item is held in the
// input register and is evaluated against the link state on its way into the output register,
// which drives m_axis_tvalid
// synchronous active-low reset clears the link state, counters and valid flags
// a stalled m_axis side holds the output register and the input register fills behind it
module radio_link_connection_manager (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // now_ms, header_valid, frame_kind, source_mac, payload_len, zero pad
    input  logic [95:0]   s_axis_tdata,
    // opcode
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status, link_state, tune_channel, channel, send_frame, sent_kind,
    // destination_mac, reconnect_total, bad_header_total, data_sent_total, zero pad
    output logic [159:0]  m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);

    logic              r_in_valid;
    rlcm_pkg::t_item   r_in;
    logic              r_out_valid;
    rlcm_pkg::t_result r_out;
    rlcm_pkg::t_cfg    r_cfg;
    rlcm_pkg::t_result w_res;
    rlcm_pkg::t_item   w_item;
    logic              w_adv;
    logic              w_fire;

    assign w_adv  = !r_out_valid || m_axis_tready;
    assign w_fire = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    assign w_item.opcode       = s_axis_tuser;
    assign w_item.now_ms       = s_axis_tdata[31:0];
    assign w_item.header_valid = s_axis_tdata[32];
    assign w_item.frame_kind   = s_axis_tdata[34:33];
    assign w_item.source_mac   = s_axis_tdata[82:35];
    assign w_item.payload_len  = s_axis_tdata[92:83];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= w_item;
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_channel      <= 4'd1;
            r_cfg.max_channel        <= 4'd13;
            r_cfg.dwell_ms           <= 16'd100;
            r_cfg.connect_timeout_ms <= 16'd500;
            r_cfg.ping_interval_ms   <= 16'd1000;
            r_cfg.max_missed_pongs   <= 8'd3;
            r_cfg.live_ms            <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rlcm_pkg::REG_FIRST_CHANNEL: r_cfg.first_channel      <= i_cfg_data[3:0];
                    rlcm_pkg::REG_MAX_CHANNEL:   r_cfg.max_channel        <= i_cfg_data[3:0];
                    rlcm_pkg::REG_DWELL:         r_cfg.dwell_ms           <= i_cfg_data;
                    rlcm_pkg::REG_CONN_TIMEOUT:  r_cfg.connect_timeout_ms <= i_cfg_data;
                    rlcm_pkg::REG_PING_INTERVAL: r_cfg.ping_interval_ms   <= i_cfg_data;
                    rlcm_pkg::REG_MAX_MISSED:    r_cfg.max_missed_pongs   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // liveness window is ping interval times (missed pongs + 1), kept in its own register
            r_cfg.live_ms <= {{(rlcm_pkg::LIVE_W-16){1'b0}}, r_cfg.ping_interval_ms}
                           * ({{(rlcm_pkg::LIVE_W-8){1'b0}}, r_cfg.max_missed_pongs}
                              + rlcm_pkg::LIVE_W'(1));
        end
    end

    rlcm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0,
                            r_out.data_sent_total,
                            r_out.bad_header_total,
                            r_out.reconnect_total,
                            r_out.destination_mac,
                            r_out.sent_kind,
                            r_out.send_frame,
                            r_out.channel,
                            r_out.tune_channel,
                            r_out.link_state,
                            r_out.status};

endmodule

// ----- bench/tb_top.sv -----
module tb_top;

    // frame kind with no meaning to the client, and register indexes past the list
    localparam logic [1:0] RX_OTHER     = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [95:0]   s_axis_tdata;   // now_ms, header_valid, frame_kind, source_mac, payload_len
    logic [1:0]    s_axis_tuser;   // opcode
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [159:0]  m_axis_tdata;   // status, link_state, tune_channel, channel, send_frame,
                                   // sent_kind, destination_mac, reconnect_total,
                                   // bad_header_total, data_sent_total
    logic          i_cfg_we;
    logic [2:0]    i_cfg_index;
    logic [15:0]   i_cfg_data;

    radio_link_connection_manager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // register mirror, reset values
    logic [3:0]  cfg_first   = 4'd1;
    logic [3:0]  cfg_max     = 4'd13;
    logic [15:0] cfg_dwell   = 16'd100;
    logic [15:0] cfg_timeout = 16'd500;
    logic [15:0] cfg_ping    = 16'd1000;
    logic [7:0]  cfg_missed  = 8'd3;

    // link state mirror
    logic        lk_ready       = 1'b0;
    logic [1:0]  lk_mode        = rlcm_pkg::MODE_UNINIT;
    logic [3:0]  lk_scan_pos    = 4'd0;
    logic        lk_retune      = 1'b0;
    logic [31:0] lk_dwell_start = '0;
    logic [31:0] lk_conn_start  = '0;
    logic [31:0] lk_pong_at     = '0;
    logic [31:0] lk_ping_at     = '0;
    logic [47:0] lk_server      = '0;
    logic [31:0] lk_reconnects  = '0;
    logic [31:0] lk_bad_headers = '0;
    logic [31:0] lk_data_sent   = '0;

    rlcm_pkg::t_result pending_results[$];
    logic [31:0] link_clock_ms;
    int          item_count     = 0;
    int          result_count   = 0;
    int          mismatch_count = 0;
    int          setting_count  = 0;
    int          tx_idle_pct    = 7;
    int          rx_idle_pct    = 7;
    int          rx_hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic rlcm_pkg::t_result next_link_result(input rlcm_pkg::t_item it);
        rlcm_pkg::t_result r;
        logic [31:0]       live;
        r = '0;
        if (it.opcode == rlcm_pkg::OP_BEGIN) begin
            lk_ready = 1'b0;
            lk_mode  = rlcm_pkg::MODE_UNINIT;
            if (cfg_dwell == 0 || cfg_timeout == 0 || cfg_ping == 0 || cfg_missed == 0 ||
                    cfg_first == 0 || cfg_first > cfg_max) begin
                r.status = rlcm_pkg::ST_BAD_CONFIG;
            end else begin
                lk_scan_pos = cfg_first;
                lk_mode     = rlcm_pkg::MODE_SCAN;
                lk_retune   = 1'b1;
                lk_ready    = 1'b1;
            end
        end else if (!lk_ready) begin
            r.status = rlcm_pkg::ST_NOT_INIT;
        end else if (it.opcode == rlcm_pkg::OP_TIME) begin
            case (lk_mode)
                rlcm_pkg::MODE_SCAN: begin
                    if (lk_retune || it.now_ms - lk_dwell_start >= {16'd0, cfg_dwell}) begin
                        if (!lk_retune)
                            lk_scan_pos = (lk_scan_pos >= cfg_max) ? 4'd1 : lk_scan_pos + 4'd1;
                        lk_retune         = 1'b0;
                        lk_dwell_start    = it.now_ms;
                        r.tune_channel    = 1'b1;
                        r.channel         = lk_scan_pos;
                        r.send_frame      = 1'b1;
                        r.sent_kind       = rlcm_pkg::TX_DISCOVER;
                        r.destination_mac = rlcm_pkg::MAC_BCAST;
                    end
                end
                rlcm_pkg::MODE_CONNECTING: begin
                    if (it.now_ms - lk_conn_start >= {16'd0, cfg_timeout}) begin
                        lk_mode   = rlcm_pkg::MODE_SCAN;
                        lk_retune = 1'b1;
                    end
                end
                rlcm_pkg::MODE_CONNECTED: begin
                    live = {16'd0, cfg_ping} * ({24'd0, cfg_missed} + 32'd1);
                    if (it.now_ms - lk_pong_at >= live) begin
                        lk_reconnects = lk_reconnects + 32'd1;
                        lk_mode       = rlcm_pkg::MODE_SCAN;
                        lk_retune     = 1'b1;
                    end else if (it.now_ms - lk_ping_at >= {16'd0, cfg_ping}) begin
                        lk_ping_at        = it.now_ms;
                        r.send_frame      = 1'b1;
                        r.sent_kind       = rlcm_pkg::TX_PING;
                        r.destination_mac = lk_server;
                    end
                end
                default: r.status = rlcm_pkg::ST_INTERNAL;
            endcase
        end else if (it.opcode == rlcm_pkg::OP_FRAME) begin
            if (!it.header_valid) begin
                lk_bad_headers = lk_bad_headers + 32'd1;
            end else begin
                case (lk_mode)
                    rlcm_pkg::MODE_SCAN: begin
                        if (it.frame_kind == rlcm_pkg::RX_OFFER) begin
                            lk_server         = it.source_mac;
                            lk_conn_start     = it.now_ms;
                            lk_mode           = rlcm_pkg::MODE_CONNECTING;
                            r.send_frame      = 1'b1;
                            r.sent_kind       = rlcm_pkg::TX_CONNREQ;
                            r.destination_mac = lk_server;
                        end
                    end
                    rlcm_pkg::MODE_CONNECTING: begin
                        if (it.frame_kind == rlcm_pkg::RX_ACCEPT &&
                                it.source_mac == lk_server) begin
                            lk_mode    = rlcm_pkg::MODE_CONNECTED;
                            lk_pong_at = it.now_ms;
                            lk_ping_at = it.now_ms;
                        end
                    end
                    rlcm_pkg::MODE_CONNECTED: begin
                        if (it.frame_kind == rlcm_pkg::RX_PONG && it.source_mac == lk_server)
                            lk_pong_at = it.now_ms;
                    end
                    default: ;
                endcase
            end
        end else begin
            if (it.payload_len == 0) begin
                r.status = rlcm_pkg::ST_BAD_ARG;
            end else if (it.payload_len > rlcm_pkg::MAX_PAYLOAD) begin
                r.status = rlcm_pkg::ST_TOO_LARGE;
            end else if (lk_mode != rlcm_pkg::MODE_CONNECTED) begin
                r.status = rlcm_pkg::ST_WOULD_BLOCK;
            end else begin
                r.send_frame      = 1'b1;
                r.sent_kind       = rlcm_pkg::TX_DATA;
                r.destination_mac = lk_server;
                lk_data_sent      = lk_data_sent + 32'd1;
            end
        end
        r.link_state       = lk_mode;
        r.reconnect_total  = lk_reconnects;
        r.bad_header_total = lk_bad_headers;
        r.data_sent_total  = lk_data_sent;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d, %s: expected %0h, got %0h", result_count, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        rlcm_pkg::t_result got;
        rlcm_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status           = m_axis_tdata[2:0];
            got.link_state       = m_axis_tdata[4:3];
            got.tune_channel     = m_axis_tdata[5];
            got.channel          = m_axis_tdata[9:6];
            got.send_frame       = m_axis_tdata[10];
            got.sent_kind        = m_axis_tdata[12:11];
            got.destination_mac  = m_axis_tdata[60:13];
            got.reconnect_total  = m_axis_tdata[92:61];
            got.bad_header_total = m_axis_tdata[124:93];
            got.data_sent_total  = m_axis_tdata[156:125];
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with nothing expected: %h",
                             result_count, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("link_state", want.link_state, got.link_state);
                check_field("tune_channel", want.tune_channel, got.tune_channel);
                check_field("channel", want.channel, got.channel);
                check_field("send_frame", want.send_frame, got.send_frame);
                check_field("sent_kind", want.sent_kind, got.sent_kind);
                check_field("destination_mac", want.destination_mac, got.destination_mac);
                check_field("reconnect_total", want.reconnect_total, got.reconnect_total);
                check_field("bad_header_total", want.bad_header_total, got.bad_header_total);
                check_field("data_sent_total", want.data_sent_total, got.data_sent_total);
            end
        end
    end

    task automatic send_link_item(input rlcm_pkg::t_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it.payload_len, it.source_mac, it.frame_kind,
                          it.header_valid, it.now_ms};
        s_axis_tuser  <= it.opcode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(next_link_result(it));
        item_count++;
    endtask

    // sender pauses until every result is back, then lets the pipeline settle
    task automatic wait_link_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            rlcm_pkg::REG_FIRST_CHANNEL: cfg_first   = val[3:0];
            rlcm_pkg::REG_MAX_CHANNEL:   cfg_max     = val[3:0];
            rlcm_pkg::REG_DWELL:         cfg_dwell   = val;
            rlcm_pkg::REG_CONN_TIMEOUT:  cfg_timeout = val;
            rlcm_pkg::REG_PING_INTERVAL: cfg_ping    = val;
            rlcm_pkg::REG_MAX_MISSED:    cfg_missed  = val[7:0];
            default: ;
        endcase
    endtask

    // narrow registers get random upper bits, which the block must drop
    task automatic apply_config(input logic [3:0] first, input logic [3:0] maxc,
                                input logic [15:0] dwell, input logic [15:0] tmo,
                                input logic [15:0] ping, input logic [7:0] missed);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(rlcm_pkg::REG_FIRST_CHANNEL, {junk[15:4], first});
        junk = 16'($urandom);
        write_reg(rlcm_pkg::REG_MAX_CHANNEL, {junk[15:4], maxc});
        write_reg(rlcm_pkg::REG_DWELL, dwell);
        write_reg(rlcm_pkg::REG_CONN_TIMEOUT, tmo);
        write_reg(rlcm_pkg::REG_PING_INTERVAL, ping);
        junk = 16'($urandom);
        write_reg(rlcm_pkg::REG_MAX_MISSED, {junk[15:8], missed});
        write_reg(REG_SPARE_LO, 16'($urandom));
        write_reg(REG_SPARE_HI, 16'($urandom));
        setting_count++;
    endtask

    function automatic rlcm_pkg::t_item link_item(input logic [1:0] op,
                                                  input logic [31:0] now,
                                                  input logic hv, input logic [1:0] kind,
                                                  input logic [47:0] mac,
                                                  input logic [9:0] len);
        rlcm_pkg::t_item it;
        it.opcode       = op;
        it.now_ms       = now;
        it.header_valid = hv;
        it.frame_kind   = kind;
        it.source_mac   = mac;
        it.payload_len  = len;
        return it;
    endfunction

    function automatic logic [31:0] time_step(input logic [31:0] span);
        return $urandom_range(0, span + span / 2 + 2);
    endfunction

    // mostly well-formed link traffic for the current mode, with some noise
    function automatic rlcm_pkg::t_item pick_link_item();
        rlcm_pkg::t_item it;
        int unsigned     roll;
        logic [63:0]     wide;
        logic [31:0]     live;
        wide            = {$urandom, $urandom};
        it.opcode       = 2'($urandom_range(0, 3));
        it.now_ms       = $urandom;
        it.header_valid = 1'($urandom_range(0, 1));
        it.frame_kind   = 2'($urandom_range(0, 3));
        it.source_mac   = wide[47:0];
        it.payload_len  = 10'($urandom_range(0, 1023));
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return it;
        it.header_valid = 1'b1;
        it.now_ms       = link_clock_ms;
        if (roll < 5) begin
            it.opcode = rlcm_pkg::OP_BEGIN;
            return it;
        end
        if (roll < 8) begin
            it.opcode       = rlcm_pkg::OP_FRAME;
            it.header_valid = 1'b0;
            return it;
        end
        roll = $urandom_range(0, 99);
        case (lk_mode)
            rlcm_pkg::MODE_SCAN: begin
                if (roll < 60) begin
                    it.opcode     = rlcm_pkg::OP_TIME;
                    link_clock_ms = link_clock_ms + time_step({16'd0, cfg_dwell});
                    it.now_ms     = link_clock_ms;
                end else if (roll < 85) begin
                    it.opcode     = rlcm_pkg::OP_FRAME;
                    it.frame_kind = rlcm_pkg::RX_OFFER;
                end else if (roll < 93) begin
                    it.opcode = rlcm_pkg::OP_FRAME;
                end else begin
                    it.opcode = rlcm_pkg::OP_SEND;
                end
            end
            rlcm_pkg::MODE_CONNECTING: begin
                if (roll < 45) begin
                    it.opcode     = rlcm_pkg::OP_FRAME;
                    it.frame_kind = rlcm_pkg::RX_ACCEPT;
                    it.source_mac = lk_server;
                end else if (roll < 55) begin
                    it.opcode     = rlcm_pkg::OP_FRAME;
                    it.frame_kind = rlcm_pkg::RX_ACCEPT;
                    it.source_mac = lk_server ^ (48'd1 << $urandom_range(0, 47));
                end else if (roll < 90) begin
                    it.opcode     = rlcm_pkg::OP_TIME;
                    link_clock_ms = link_clock_ms + time_step({16'd0, cfg_timeout});
                    it.now_ms     = link_clock_ms;
                end else begin
                    it.opcode = rlcm_pkg::OP_SEND;
                end
            end
            rlcm_pkg::MODE_CONNECTED: begin
                live = {16'd0, cfg_ping} * ({24'd0, cfg_missed} + 32'd1);
                if (roll < 30) begin
                    it.opcode     = rlcm_pkg::OP_TIME;
                    link_clock_ms = link_clock_ms + time_step({16'd0, cfg_ping});
                    it.now_ms     = link_clock_ms;
                end else if (roll < 34) begin
                    // jump past the liveness window
                    it.opcode     = rlcm_pkg::OP_TIME;
                    link_clock_ms = link_clock_ms + live + $urandom_range(0, cfg_ping);
                    it.now_ms     = link_clock_ms;
                end else if (roll < 55) begin
                    it.opcode     = rlcm_pkg::OP_FRAME;
                    it.frame_kind = rlcm_pkg::RX_PONG;
                    it.source_mac = lk_server;
                end else if (roll < 60) begin
                    it.opcode     = rlcm_pkg::OP_FRAME;
                    it.source_mac = lk_server ^ (48'd1 << $urandom_range(0, 47));
                end else if (roll < 90) begin
                    it.opcode      = rlcm_pkg::OP_SEND;
                    it.payload_len = 10'($urandom_range(1, rlcm_pkg::MAX_PAYLOAD));
                end else begin
                    it.opcode = rlcm_pkg::OP_SEND;
                end
            end
            default: begin
                if (roll < 80)
                    it.opcode = rlcm_pkg::OP_BEGIN;
            end
        endcase
        return it;
    endfunction

    task automatic test_before_begin();
        send_link_item(link_item(rlcm_pkg::OP_TIME, 32'hFFFF_FFFF, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, 32'd0, 1'b1, rlcm_pkg::RX_OFFER,
                                 48'h1234_5678_9ABC, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, 32'd0, 1'b0, rlcm_pkg::RX_PONG,
                                 '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_SEND, 32'd0, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd5));
        wait_link_idle();
    endtask

    task automatic test_bad_config();
        apply_config(4'd1, 4'd13, 16'd100, 16'd500, 16'd1000, 8'd3);
        send_link_item(link_item(rlcm_pkg::OP_BEGIN, 32'd0, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd0));
        wait_link_idle();
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: apply_config(4'd1, 4'd13, 16'd0, 16'd500, 16'd1000, 8'd3);
                1: apply_config(4'd1, 4'd13, 16'd100, 16'd0, 16'd1000, 8'd3);
                2: apply_config(4'd1, 4'd13, 16'd100, 16'd500, 16'd0, 8'd3);
                3: apply_config(4'd1, 4'd13, 16'd100, 16'd500, 16'd1000, 8'd0);
                4: apply_config(4'd0, 4'd13, 16'd100, 16'd500, 16'd1000, 8'd3);
                default: apply_config(4'd9, 4'd8, 16'd100, 16'd500, 16'd1000, 8'd3);
            endcase
            send_link_item(link_item(rlcm_pkg::OP_BEGIN, 32'd0, 1'b1, rlcm_pkg::RX_OFFER,
                                     '0, 10'd0));
            wait_link_idle();
        end
        // failed begin drops a running link back to not ready
        send_link_item(link_item(rlcm_pkg::OP_TIME, 32'd0, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd0));
        wait_link_idle();
    endtask

    task automatic test_connection_flow();
        logic [31:0] t0;
        logic [31:0] t1;
        logic [47:0] srv;
        t0  = 32'hFFFF_FF00;
        t1  = t0 + 32'd65535;
        srv = 48'hFFFF_FFFF_FFFF;
        apply_config(4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_link_item(link_item(rlcm_pkg::OP_BEGIN, t0, 1'b1, rlcm_pkg::RX_OFFER, '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_TIME, t0, 1'b1, rlcm_pkg::RX_OFFER, '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_TIME, t0 + 32'd100, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd0));
        // dwell expires across the timestamp wrap, channel wraps to one
        send_link_item(link_item(rlcm_pkg::OP_TIME, t1, 1'b1, rlcm_pkg::RX_OFFER, '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, t1, 1'b1, rlcm_pkg::RX_ACCEPT,
                                 srv, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, t1, 1'b1, rlcm_pkg::RX_OFFER,
                                 srv, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, t1, 1'b1, rlcm_pkg::RX_ACCEPT,
                                 48'd0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, t1, 1'b1, rlcm_pkg::RX_ACCEPT,
                                 srv, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_SEND, t1, 1'b1, rlcm_pkg::RX_OFFER, '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_SEND, t1, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd1023));
        send_link_item(link_item(rlcm_pkg::OP_SEND, t1, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, rlcm_pkg::MAX_PAYLOAD + 10'd1));
        send_link_item(link_item(rlcm_pkg::OP_SEND, t1, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, rlcm_pkg::MAX_PAYLOAD));
        send_link_item(link_item(rlcm_pkg::OP_TIME, t1 + 32'd65535, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, t1 + 32'd65535, 1'b1, rlcm_pkg::RX_PONG,
                                 srv, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, t1 + 32'd65535, 1'b1, RX_OTHER,
                                 srv, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, t1 + 32'd65535, 1'b0, rlcm_pkg::RX_PONG,
                                 srv, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_TIME, t1 + 32'd65535 + 32'd16776961, 1'b1,
                                 rlcm_pkg::RX_OFFER, '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_SEND, t1, 1'b1, rlcm_pkg::RX_OFFER, '0, 10'd1));
        wait_link_idle();
    endtask

    task automatic test_connect_timeout();
        logic [31:0] t;
        t = 32'h8000_0000;
        apply_config(4'd1, 4'd1, 16'd1, 16'd1, 16'd1, 8'd1);
        send_link_item(link_item(rlcm_pkg::OP_BEGIN, t, 1'b1, rlcm_pkg::RX_OFFER, '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_TIME, t, 1'b1, rlcm_pkg::RX_OFFER, '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, t, 1'b1, rlcm_pkg::RX_OFFER,
                                 48'd0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_TIME, t + 32'd1, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_TIME, t + 32'd1, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd0));
        wait_link_idle();
    endtask

    // registers changed after begin take effect without a check
    task automatic test_live_register_change();
        logic [31:0] t;
        logic [47:0] srv;
        t   = 32'h0001_0000;
        srv = 48'hA5A5_5A5A_0F0F;
        apply_config(4'd5, 4'd13, 16'd10, 16'd50, 16'd20, 8'd2);
        send_link_item(link_item(rlcm_pkg::OP_BEGIN, t, 1'b1, rlcm_pkg::RX_OFFER, '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_TIME, t, 1'b1, rlcm_pkg::RX_OFFER, '0, 10'd0));
        wait_link_idle();
        write_reg(rlcm_pkg::REG_MAX_CHANNEL, 16'd3);
        send_link_item(link_item(rlcm_pkg::OP_TIME, t + 32'd10, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd0));
        wait_link_idle();
        write_reg(rlcm_pkg::REG_DWELL, 16'd0);
        send_link_item(link_item(rlcm_pkg::OP_TIME, t + 32'd10, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, t + 32'd10, 1'b1, rlcm_pkg::RX_OFFER,
                                 srv, 10'd0));
        send_link_item(link_item(rlcm_pkg::OP_FRAME, t + 32'd10, 1'b1, rlcm_pkg::RX_ACCEPT,
                                 srv, 10'd0));
        wait_link_idle();
        write_reg(rlcm_pkg::REG_PING_INTERVAL, 16'd0);
        send_link_item(link_item(rlcm_pkg::OP_TIME, t + 32'd10, 1'b1, rlcm_pkg::RX_OFFER,
                                 '0, 10'd0));
        wait_link_idle();
    endtask

    task automatic test_random_traffic();
        logic [3:0] first;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: apply_config(4'd1, 4'd13, 16'd100, 16'd500, 16'd1000, 8'd3);
                1: apply_config(4'd3, 4'd5, 16'd7, 16'd20, 16'd10, 8'd2);
                2: apply_config(4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
                3: apply_config(4'd1, 4'd1, 16'd1, 16'd1, 16'd1, 8'd1);
                default: begin
                    first = 4'($urandom_range(1, 15));
                    apply_config(first, 4'($urandom_range(first, 15)),
                                 16'($urandom_range(1, 3000)),
                                 16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
                                 8'($urandom_range(1, 255)));
                end
            endcase
            // one phase runs with both sides always willing
            if (phase == 1) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 7;
                rx_idle_pct = 7;
            end
            link_clock_ms = $urandom;
            send_link_item(link_item(rlcm_pkg::OP_BEGIN, link_clock_ms, 1'b1,
                                     rlcm_pkg::RX_OFFER, '0, 10'd0));
            repeat (200) send_link_item(pick_link_item());
            wait_link_idle();
        end
        tx_idle_pct = 7;
        rx_idle_pct = 7;
    endtask

    // output held off while the sender keeps offering, so the input side stalls
    task automatic test_output_stall();
        rx_hold_cycles = 300;
        repeat (40) send_link_item(pick_link_item());
        wait_link_idle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= rlcm_pkg::OP_BEGIN;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= rlcm_pkg::REG_FIRST_CHANNEL;
        i_cfg_data    <= '0;
        link_clock_ms = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_begin();
        test_bad_config();
        test_connection_flow();
        test_connect_timeout();
        test_live_register_change();
        test_random_traffic();
        test_output_stall();
        wait_link_idle();

        $display("%0d items sent, %0d results checked, %0d register settings applied",
                 item_count, result_count, setting_count);
        $display("scan, connect, ping, reconnect, timeouts, bad config and a long output stall");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_count, pending_results.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
